@@ hw/rtl/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants, types and helpers of the sparse-table range-max engine.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_WIDTH  = 32;

  // fixed port widths
  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 32;
  localparam int RNG_W    = 10;
  localparam int STAT_W   = 2;
  localparam int LOADED_W = 11;

  localparam int IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int TAB_DEPTH = LEVELS * MAX_ELEMENTS;
  localparam int ADDR_W    = $clog2(TAB_DEPTH);
  localparam int SPAN_W    = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
  localparam int KW        = $clog2(RNG_W + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_QUERY   = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_QRD1,
    S_QRD2,
    S_RESP
  } state_e;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   range_max;
    status_e             status;
    logic [LOADED_W-1:0] loaded_count;
  } result_t;

  // level-major table layout
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [IDX_W-1:0] idx);
    return ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx);
  endfunction

  function automatic logic [SPAN_W-1:0] span(input logic [LVL_W-1:0] lvl);
    return SPAN_W'(1) << lvl;
  endfunction

  function automatic logic [KW-1:0] floor_log2(input logic [RNG_W:0] len);
    logic [KW-1:0] k;
    k = '0;
    for (int i = 0; i <= RNG_W; i++) begin
      if (len[i]) k = KW'(i);
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/rmst_mem.sv @@
// ----------------------------------------------------------------------------
// rmst_mem
// Window-max table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rmst_mem (
  input  logic                            clk_i,
  input  rmst_pkg::mem_req_t              req_i,
  output logic [rmst_pkg::VALUE_WIDTH-1:0] rdata_o
);
  import rmst_pkg::*;

  logic [VALUE_WIDTH-1:0] mem_q [TAB_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rmst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: incremental table build on append, two-window lookup on query.
// ----------------------------------------------------------------------------
module rmst_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rmst_pkg::FUNC_W-1:0]      func_i,
  input  logic [rmst_pkg::DATA_W-1:0]      element_value_i,
  input  logic [rmst_pkg::RNG_W-1:0]       range_low_i,
  input  logic [rmst_pkg::RNG_W-1:0]       range_high_i,
  output rmst_pkg::mem_req_t               mem_req_o,
  input  logic [rmst_pkg::VALUE_WIDTH-1:0] mem_rdata_i,
  output logic                             res_valid_o,
  output rmst_pkg::result_t                res_o,
  input  logic                             out_free_i
);
  import rmst_pkg::*;

  state_e                 state_q, state_d;
  logic [FUNC_W-1:0]      func_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [RNG_W-1:0]       lo_q, hi_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [LVL_W-1:0]       lvl_q, lvl_d;
  logic [LVL_W-1:0]       wl_q, wl_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [VALUE_WIDTH-1:0] m_q, m_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [ADDR_W-1:0]      b_addr_q, b_addr_d;
  result_t                res_q, res_d;

  logic                   in_fire;
  logic                   full, bad;
  logic [RNG_W:0]         len, second;
  logic [KW-1:0]          k_raw;
  logic [LVL_W-1:0]       k;
  logic [SPAN_W-1:0]      idx1;
  logic                   issue;
  logic [VALUE_WIDTH-1:0] m_new, q_max;

  assign in_fire = in_valid_i && in_ready_o;

  // query decode
  assign len    = {1'b0, hi_q} - {1'b0, lo_q} + (RNG_W+1)'(1);
  assign bad    = (lo_q > hi_q) || (int'(hi_q) >= int'(cnt_q)) ||
                  (int'(hi_q) >= MAX_ELEMENTS);
  assign k_raw  = floor_log2(len);
  assign k      = (int'(k_raw) > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(k_raw);
  assign second = {1'b0, hi_q} + (RNG_W+1)'(1) - ((RNG_W+1)'(1) << k);
  assign full   = (cnt_q == CNT_W'(MAX_ELEMENTS));

  // append: level lvl window starts at idx+1-2^lvl
  assign idx1  = SPAN_W'(idx_q) + SPAN_W'(1);
  assign issue = (lvl_q < LVL_W'(LEVELS)) && (span(lvl_q) <= idx1);
  assign m_new = (mem_rdata_i > m_q) ? mem_rdata_i : m_q;
  assign q_max = (mem_rdata_i > a_q) ? mem_rdata_i : a_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        unique case (func_q)
          FUNC_APPEND: state_d = full ? S_RESP : S_APPEND;
          FUNC_QUERY:  state_d = bad ? S_RESP : S_QRD1;
          default:     state_d = S_RESP;
        endcase
      end
      // last level write, if any, goes out in the same cycle
      S_APPEND: if (!issue) state_d = S_RESP;
      S_QRD1:   state_d = S_QRD2;
      S_QRD2:   state_d = S_RESP;
      S_RESP:   if (out_free_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    wl_d        = wl_q;
    rd_pend_d   = rd_pend_q;
    m_d         = m_q;
    a_d         = a_q;
    b_addr_d    = b_addr_q;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_EXEC: begin
        res_d.range_max    = '0;
        res_d.status       = STAT_OK;
        res_d.loaded_count = LOADED_W'(cnt_q);
        unique case (func_q)
          FUNC_APPEND: begin
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              mem_req_o.we       = 1'b1;
              mem_req_o.waddr    = tab_addr('0, IDX_W'(cnt_q));
              mem_req_o.wdata    = value_q;
              m_d                = value_q;
              idx_d              = IDX_W'(cnt_q);
              lvl_d              = LVL_W'(1);
              rd_pend_d          = 1'b0;
              cnt_d              = cnt_q + CNT_W'(1);
              res_d.loaded_count = LOADED_W'(cnt_q + CNT_W'(1));
            end
          end
          FUNC_QUERY: begin
            if (bad) begin
              res_d.status = STAT_BAD_RANGE;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = tab_addr(k, IDX_W'(lo_q));
              b_addr_d        = tab_addr(k, IDX_W'(second));
            end
          end
          FUNC_RESTART: begin
            cnt_d              = '0;
            res_d.loaded_count = '0;
          end
          default: ;
        endcase
      end
      S_APPEND: begin
        // read of level l-1 returns next cycle; combine with running max
        if (rd_pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = tab_addr(wl_q, IDX_W'(idx1 - span(wl_q)));
          mem_req_o.wdata = m_new;
          m_d             = m_new;
        end
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tab_addr(lvl_q - LVL_W'(1), IDX_W'(idx1 - span(lvl_q)));
          wl_d            = lvl_q;
          lvl_d           = lvl_q + LVL_W'(1);
          rd_pend_d       = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
      end
      S_QRD1: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = b_addr_q;
        a_d             = mem_rdata_i;
      end
      S_QRD2: res_d.range_max = DATA_W'(q_max);
      S_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_i;
      value_q <= VALUE_WIDTH'(element_value_i);
      lo_q    <= range_low_i;
      hi_q    <= range_high_i;
    end
    idx_q    <= idx_d;
    lvl_q    <= lvl_d;
    wl_q     <= wl_d;
    m_q      <= m_d;
    a_q      <= a_d;
    b_addr_q <= b_addr_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/range_max_sparse_table.sv @@
// ----------------------------------------------------------------------------
// range_max_sparse_table
// Range-maximum engine over a sparse table built as elements are appended.
// ----------------------------------------------------------------------------
// Input words carry func (append, query, restart), a value and an inclusive
// index range; every input word yields exactly one output word with the
// range max, a status and the element count after the word.
// One word is in flight at a time. Steps from input accept to output valid:
//   append:  write of the element, then levels 1 .. min(floor(log2(n)),
//            LEVELS-1), n = elements after append; one table level per
//            cycle, set by the single read port of the table memory.
//   query:   two reads of the same port plus a compare.
//   restart, full table, bad range, unused func: decode, then the result.
// The input is ready again once the result has entered the output
// register.
// Reset empties the table (count zero); the table memory is not cleared,
// since entries are always written before they can be read.
// The output word sits in a register; a stalled receiver holds it there and
// the next word can be accepted, but its result waits until the register
// is free.
// ----------------------------------------------------------------------------
module range_max_sparse_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rmst_pkg::FUNC_W-1:0]   func_i,
  input  logic [rmst_pkg::DATA_W-1:0]   element_value_i,
  input  logic [rmst_pkg::RNG_W-1:0]    range_low_i,
  input  logic [rmst_pkg::RNG_W-1:0]    range_high_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmst_pkg::DATA_W-1:0]   range_max_o,
  output logic [rmst_pkg::STAT_W-1:0]   status_o,
  output logic [rmst_pkg::LOADED_W-1:0] loaded_count_o
);
  import rmst_pkg::*;

  mem_req_t               mem_req;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   res_valid;
  result_t                res;
  logic                   out_free;
  logic                   out_valid_q;
  result_t                out_q;

  assign out_free = !out_valid_q || out_ready_i;

  rmst_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .element_value_i (element_value_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .out_free_i      (out_free)
  );

  rmst_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) out_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign range_max_o    = out_q.range_max;
  assign status_o       = out_q.status;
  assign loaded_count_o = out_q.loaded_count;

  // one word at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> range_max_o == '0)
    else $error("nonzero max with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> loaded_count_o <= LOADED_W'(MAX_ELEMENTS))
    else $error("count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> loaded_count_o == LOADED_W'(MAX_ELEMENTS))
    else $error("full status with table not full");

endmodule

@@ tb/range_max_sparse_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_sparse_table_tb
// Self-checking bench for the sparse-table range-max engine.
// ----------------------------------------------------------------------------
// A queue of input words (directed corner cases, then random build/query
// sessions) feeds a clocked driver. Every accepted word is run through a
// local sparse-table model whose answer is queued; a clocked monitor
// compares each output word, field by field, with the oldest queued answer.
// Both sides idle at random and the receiver holds off once for a long
// stretch to back up the input.
// ----------------------------------------------------------------------------
module range_max_sparse_table_tb;
  import rmst_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    logic [RNG_W-1:0]  lo;
    logic [RNG_W-1:0]  hi;
  } word_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i          = '0;
  logic [DATA_W-1:0]   element_value_i = '0;
  logic [RNG_W-1:0]    range_low_i     = '0;
  logic [RNG_W-1:0]    range_high_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [DATA_W-1:0]   range_max_o;
  logic [STAT_W-1:0]   status_o;
  logic [LOADED_W-1:0] loaded_count_o;

  range_max_sparse_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .element_value_i(element_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_max_o    (range_max_o),
    .status_o       (status_o),
    .loaded_count_o (loaded_count_o)
  );

  always #2 clk_i = ~clk_i;

  word_t   stim_words[$];
  result_t pending_answers[$];
  int      errors = 0;

  // model of the table: win_max[j][s] = max of elements s .. s+2^j-1
  logic [VALUE_WIDTH-1:0] win_max [LEVELS][MAX_ELEMENTS];
  int unsigned            model_count = 0;

  function automatic result_t table_step(word_t w);
    result_t     r;
    int unsigned len, k, start, second;
    r.range_max    = '0;
    r.status       = STAT_OK;
    case (w.func)
      FUNC_APPEND: begin
        if (model_count >= MAX_ELEMENTS) begin
          r.status = STAT_FULL;
        end else begin
          win_max[0][model_count] = w.value;
          for (int j = 1; j < LEVELS; j++) begin
            if ((1 << j) > model_count + 1) break;
            start = model_count + 1 - (1 << j);
            win_max[j][start] = (win_max[j-1][start] > win_max[j-1][start + (1 << (j-1))]) ?
                                win_max[j-1][start] : win_max[j-1][start + (1 << (j-1))];
          end
          model_count++;
        end
      end
      FUNC_QUERY: begin
        if (w.lo > w.hi || w.hi >= model_count) begin
          r.status = STAT_BAD_RANGE;
        end else begin
          len = w.hi - w.lo + 1;
          k   = 0;
          while ((len >> (k + 1)) != 0) k++;
          if (k > LEVELS - 1) k = LEVELS - 1;
          second      = w.hi + 1 - (1 << k);
          r.range_max = (win_max[k][w.lo] > win_max[k][second]) ?
                        win_max[k][w.lo] : win_max[k][second];
        end
      end
      FUNC_RESTART: model_count = 0;
      default: ;
    endcase
    r.loaded_count = LOADED_W'(model_count);
    return r;
  endfunction

  // ---- stimulus generation --------------------------------------------------
  int unsigned     gen_count  = 0;
  logic [DATA_W-1:0] last_value = '0;

  task automatic add_word(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v,
                          logic [RNG_W-1:0] lo, logic [RNG_W-1:0] hi);
    word_t w;
    w.func  = f;
    w.value = v;
    w.lo    = lo;
    w.hi    = hi;
    stim_words.insert(stim_words.size(), w);
    if (f == FUNC_APPEND && gen_count < MAX_ELEMENTS) gen_count++;
    if (f == FUNC_RESTART) gen_count = 0;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom_range(0, 15);
      1:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
      2:       v = last_value;
      default: v = $urandom;
    endcase
    last_value = v;
    return v;
  endfunction

  task automatic add_append(logic [DATA_W-1:0] v);
    add_word(FUNC_APPEND, v, RNG_W'($urandom), RNG_W'($urandom));
  endtask

  task automatic add_query(int lo, int hi);
    add_word(FUNC_QUERY, $urandom, RNG_W'(lo), RNG_W'(hi));
  endtask

  // in-range query; needs gen_count > 0
  task automatic add_random_query();
    int lo, hi;
    lo = $urandom_range(0, gen_count - 1);
    case ($urandom_range(0, 9))
      0: begin
        lo = 0;
        hi = gen_count - 1;
      end
      1, 2, 3: begin
        hi = lo + $urandom_range(0, 3);
        if (hi > gen_count - 1) hi = gen_count - 1;
      end
      default: hi = $urandom_range(lo, gen_count - 1);
    endcase
    add_query(lo, hi);
  endtask

  task automatic add_noise();
    int lo;
    case ($urandom_range(0, 3))
      0: add_word(FUNC_UNUSED, $urandom, RNG_W'($urandom), RNG_W'($urandom));
      1: begin
        lo = $urandom_range(1, 1023);
        add_query(lo, $urandom_range(0, lo - 1));
      end
      2: begin
        if (gen_count < 1024) add_query($urandom_range(0, 1023), $urandom_range(gen_count, 1023));
        else add_query(1023, 0);
      end
      default: add_word(FUNC_W'($urandom), $urandom, RNG_W'($urandom), RNG_W'($urandom));
    endcase
  endtask

  // ---- idling -------------------------------------------------------------
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---- driver -------------------------------------------------------------
  word_t cur_word;
  int    send_gap   = 0;
  int    send_quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      func_i          <= '0;
      element_value_i <= '0;
      range_low_i     <= '0;
      range_high_i    <= '0;
      send_gap        = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_answers.insert(pending_answers.size(), table_step(cur_word));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_words.size() != 0) begin
          cur_word         = stim_words.pop_front();
          func_i          <= cur_word.func;
          element_value_i <= cur_word.value;
          range_low_i     <= cur_word.lo;
          range_high_i    <= cur_word.hi;
          in_valid_i      <= 1'b1;
          if (send_quiet > 0) begin
            send_quiet--;
            send_gap = 0;
          end else begin
            send_gap = pick_idle();
            if ($urandom_range(0, 49) == 0) send_quiet = 30;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ------------------------------------------------------------
  int      words_seen = 0;
  int      recv_stall = 0;
  int      recv_quiet = 0;
  result_t exp_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          $error("output word with no pending answer");
          errors++;
        end else begin
          exp_word = pending_answers.pop_front();
          if (range_max_o !== exp_word.range_max) begin
            $error("range_max: expected %h, got %h", exp_word.range_max, range_max_o);
            errors++;
          end
          if (status_o !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, status_o);
            errors++;
          end
          if (loaded_count_o !== exp_word.loaded_count) begin
            $error("loaded_count: expected %0d, got %0d", exp_word.loaded_count,
                   loaded_count_o);
            errors++;
          end
        end
        words_seen++;
        if (recv_quiet > 0) begin
          recv_quiet--;
          recv_stall = 0;
        end else begin
          recv_stall = pick_idle();
          if ($urandom_range(0, 49) == 0) recv_quiet = 30;
        end
        // long hold-off so the block fills and stalls its input
        if (words_seen == 200) recv_stall = 300;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---- sequence -----------------------------------------------------------
  initial begin
    int len, r;

    // directed corners
    add_query(0, 0);
    add_word(FUNC_RESTART, '0, '0, '0);
    add_append(32'h0000_0000);
    add_append(32'hFFFF_FFFF);
    add_append(32'd5);
    add_query(0, 0);
    add_query(1, 1);
    add_query(0, 2);
    add_query(2, 2);
    add_query(2, 1);
    add_query(0, 3);
    add_query(1023, 1023);
    add_word(FUNC_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
    add_append(32'd1);
    add_append(32'd7);
    add_append(32'd3);
    add_append(32'hFFFF_FFFE);
    add_append(32'd2);
    add_query(0, 7);
    add_query(1, 6);
    add_query(3, 4);
    add_word(FUNC_RESTART, '1, '1, '1);
    add_query(0, 0);
    add_append(32'd9);
    add_query(0, 0);

    // random sessions: restart, then a build with interleaved queries and noise
    while (stim_words.size() < 750) begin
      add_word(FUNC_RESTART, $urandom, RNG_W'($urandom), RNG_W'($urandom));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(10, 50);
      if (len > 750 - stim_words.size()) len = 750 - stim_words.size();
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (gen_count == 0 || r < 50) add_append(rand_value());
        else if (r < 88) add_random_query();
        else add_noise();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (stim_words.size() != 0 || in_valid_i || pending_answers.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
